// ===== hw/rtl/minv_pkg.sv =====
`timescale 1ns / 1ps
package minv_pkg;

  localparam int unsigned EntryW = 32;
  localparam int unsigned ProdW  = 2 * EntryW;        // entry x entry
  localparam int unsigned AdjW   = ProdW + 1;         // difference of two products
  localparam int unsigned LoW    = EntryW;            // low slice of an adjugate entry
  localparam int unsigned HiW    = AdjW - LoW;        // high slice, signed
  localparam int unsigned PartW  = EntryW + HiW;      // entry x slice
  localparam int unsigned TermW  = EntryW + AdjW;     // entry x adjugate entry
  localparam int unsigned DetW   = TermW + 2;         // sum of three terms
  localparam int unsigned DenW   = DetW + 1;          // twice the determinant magnitude
  localparam int unsigned DivW   = EntryW - 1;        // quotient bits below saturation
  localparam int unsigned DivStages = DivW + 2;       // range check, bits, result

  localparam logic signed [EntryW-1:0] ResMax = {1'b0, {(EntryW-1){1'b1}}};
  localparam logic signed [EntryW-1:0] ResMin = {1'b1, {(EntryW-1){1'b0}}};

  // rounding numerator 2*|adj|*2^(2F) + |det|
  function automatic int unsigned num_w(int unsigned frac_bits);
    int unsigned mag;
    mag = AdjW + 2 * frac_bits + 1;
    return ((mag > DetW) ? mag : DetW) + 1;
  endfunction

  function automatic int unsigned rem_w(int unsigned frac_bits);
    int unsigned n;
    n = num_w(frac_bits);
    return (n > DenW + DivW) ? n : DenW + DivW;
  endfunction

  typedef struct packed {
    logic signed [EntryW-1:0] a11;
    logic signed [EntryW-1:0] a12;
    logic signed [EntryW-1:0] a13;
    logic signed [EntryW-1:0] a21;
    logic signed [EntryW-1:0] a22;
    logic signed [EntryW-1:0] a23;
    logic signed [EntryW-1:0] a31;
    logic signed [EntryW-1:0] a32;
    logic signed [EntryW-1:0] a33;
  } in_t;

  typedef struct packed {
    logic signed [EntryW-1:0] b11;
    logic signed [EntryW-1:0] b12;
    logic signed [EntryW-1:0] b13;
    logic signed [EntryW-1:0] b21;
    logic signed [EntryW-1:0] b22;
    logic signed [EntryW-1:0] b23;
    logic signed [EntryW-1:0] b31;
    logic signed [EntryW-1:0] b32;
    logic signed [EntryW-1:0] b33;
    logic signed [EntryW-1:0] det_value;
    logic                     singular;
  } out_t;

endpackage

// ===== hw/rtl/minv_div.sv =====
`timescale 1ns / 1ps
module minv_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                       clk_i,
  input  logic [minv_pkg::DivStages-1:0]             en_i,
  input  logic [minv_pkg::num_w(FRAC_BITS)-1:0]      num_i,
  input  logic [minv_pkg::DenW-1:0]                  den_i,
  input  logic                                       neg_i,
  input  logic                                       clr_i,
  output logic signed [minv_pkg::EntryW-1:0]         res_o
);
  import minv_pkg::*;

  localparam int unsigned RemW = rem_w(FRAC_BITS);

  logic [RemW-1:0]          rem_q [DivW];
  logic [DenW-1:0]          den_q [DivW];
  logic [DivW-1:0]          quo_q [DivW+1];
  logic                     neg_q [DivW+1];
  logic                     sat_q [DivW+1];
  logic                     clr_q [DivW+1];
  logic [RemW-1:0]          sub_w [DivW];
  logic                     ge_w  [DivW];
  logic signed [EntryW-1:0] mag_w;
  logic signed [EntryW-1:0] res_d;
  logic signed [EntryW-1:0] res_q;

  // one restoring step per stage, quotient MSB first
  always_comb begin
    for (int j = 0; j < DivW; j++) begin
      sub_w[j] = RemW'(den_q[j]) << (DivW - 1 - j);
      ge_w[j]  = rem_q[j] >= sub_w[j];
    end
  end

  always_comb begin
    mag_w = {1'b0, quo_q[DivW]};
    if (clr_q[DivW]) begin
      res_d = '0;
    end else if (sat_q[DivW]) begin
      res_d = neg_q[DivW] ? ResMin : ResMax;
    end else if (neg_q[DivW]) begin
      res_d = -mag_w;
    end else begin
      res_d = mag_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0] <= RemW'(num_i);
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      sat_q[0] <= RemW'(num_i) >= (RemW'(den_i) << DivW);
      neg_q[0] <= neg_i;
      clr_q[0] <= clr_i;
    end
    for (int j = 1; j < DivW; j++) begin
      if (en_i[j]) begin
        rem_q[j] <= ge_w[j-1] ? rem_q[j-1] - sub_w[j-1] : rem_q[j-1];
        den_q[j] <= den_q[j-1];
      end
    end
    for (int j = 1; j <= DivW; j++) begin
      if (en_i[j]) begin
        quo_q[j] <= {quo_q[j-1][DivW-2:0], ge_w[j-1]};
        neg_q[j] <= neg_q[j-1];
        sat_q[j] <= sat_q[j-1];
        clr_q[j] <= clr_q[j-1];
      end
    end
    if (en_i[DivW+1]) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== hw/rtl/matrix3x3_inverse.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake                 Transaction
// in       sink       in_valid_i / in_stall_o   one 3x3 matrix, nine Q16.16 entries
// out      source     out_valid_o / out_stall_i inverse, determinant, singular flag
//
// One transaction per cycle while out_stall_i is low.
// Seven arithmetic stages (products, adjugate, split multiply, terms, determinant,
// magnitudes, numerators) feed nine 33-stage restoring dividers: a range check,
// then one quotient bit per stage for 31 stages, then the signed result.
// Reset clears only the stage valid bits; payload registers are not reset.
// Each stage holds while it is full and the one after it is held, so bubbles close up and
// input is taken while a finished result waits at the output, as long as some stage is empty.
module matrix3x3_inverse #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  minv_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output minv_pkg::out_t   out_data_o
);
  import minv_pkg::*;

  localparam int unsigned NumW    = num_w(FRAC_BITS);
  localparam int unsigned DivBase = 7;
  localparam int unsigned NS      = DivBase + DivStages;
  localparam logic [DetW:0] HalfLsb = (DetW + 1)'(1) << (2 * FRAC_BITS - 1);

  // cofactor k = m[X]*m[Y] - m[Z]*m[W], already transposed
  localparam int unsigned CofX [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int unsigned CofY [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int unsigned CofZ [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int unsigned CofW [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
  // first-row expansion picks these adjugate entries
  localparam int unsigned DetCol [3] = '{0, 3, 6};

  // handshake chain: a stage loads when empty or when the next one loads
  logic [NS-1:0] vld_q;
  logic [NS:0]   en_w;

  assign en_w[NS] = !out_stall_i;
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en_w[k] = !vld_q[k] || en_w[k+1];
  end

  assign in_stall_o  = !en_w[0];
  assign out_valid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en_w[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en_w[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // stage 0: eighteen entry products
  logic signed [EntryW-1:0] m_w [9];
  logic signed [ProdW-1:0]  pa_d [9];
  logic signed [ProdW-1:0]  pb_d [9];
  logic signed [ProdW-1:0]  pa_q [9];
  logic signed [ProdW-1:0]  pb_q [9];
  logic signed [EntryW-1:0] row_q [2][3];

  assign m_w[0] = in_data_i.a11;
  assign m_w[1] = in_data_i.a12;
  assign m_w[2] = in_data_i.a13;
  assign m_w[3] = in_data_i.a21;
  assign m_w[4] = in_data_i.a22;
  assign m_w[5] = in_data_i.a23;
  assign m_w[6] = in_data_i.a31;
  assign m_w[7] = in_data_i.a32;
  assign m_w[8] = in_data_i.a33;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      pa_d[k] = m_w[CofX[k]] * m_w[CofY[k]];
      pb_d[k] = m_w[CofZ[k]] * m_w[CofW[k]];
    end
  end

  // stage 1: exact adjugate; stages 2..4 carry it alongside the determinant
  logic signed [AdjW-1:0] adj_q [4][9];

  // stage 2: each first-row entry times low and high slice of its cofactor
  logic signed [LoW:0]    lo_w [3];
  logic signed [HiW-1:0]  hi_w [3];
  logic signed [PartW-1:0] pl_d [3];
  logic signed [PartW-1:0] ph_d [3];
  logic signed [PartW-1:0] pl_q [3];
  logic signed [PartW-1:0] ph_q [3];

  always_comb begin
    for (int t = 0; t < 3; t++) begin
      lo_w[t] = $signed({1'b0, adj_q[0][DetCol[t]][LoW-1:0]});
      hi_w[t] = $signed(adj_q[0][DetCol[t]][AdjW-1:LoW]);
      pl_d[t] = row_q[1][t] * lo_w[t];
      ph_d[t] = row_q[1][t] * hi_w[t];
    end
  end

  // stage 3: recombine slices; stage 4: sum of terms
  logic signed [TermW-1:0] term_q [3];
  logic signed [DetW-1:0]  det_q;

  // stage 5: signs and magnitudes
  logic [DetW-1:0] dabs_q;
  logic            dneg5_q;
  logic            zero5_q;
  logic [AdjW-1:0] aabs_q [9];
  logic            aneg_q [9];

  // stage 6: rounding numerators, doubled divisor, rounded determinant magnitude
  logic [NumW-1:0] num_q [9];
  logic [DenW-1:0] den_q;
  logic            neg_q [9];
  logic            zero6_q;
  logic            dneg6_q;
  logic [DetW:0]   dsum_w;
  logic [DetW:0]   dmag_q;

  assign dsum_w = {1'b0, dabs_q} + HalfLsb;

  always_ff @(posedge clk_i) begin
    if (en_w[0]) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
      row_q[0][0] <= m_w[0];
      row_q[0][1] <= m_w[1];
      row_q[0][2] <= m_w[2];
    end
    if (en_w[1]) begin
      for (int k = 0; k < 9; k++) begin
        adj_q[0][k] <= AdjW'(pa_q[k]) - AdjW'(pb_q[k]);
      end
      row_q[1] <= row_q[0];
    end
    if (en_w[2]) begin
      pl_q <= pl_d;
      ph_q <= ph_d;
      adj_q[1] <= adj_q[0];
    end
    if (en_w[3]) begin
      for (int t = 0; t < 3; t++) begin
        term_q[t] <= (TermW'(ph_q[t]) <<< LoW) + TermW'(pl_q[t]);
      end
      adj_q[2] <= adj_q[1];
    end
    if (en_w[4]) begin
      det_q <= DetW'(term_q[0]) + DetW'(term_q[1]) + DetW'(term_q[2]);
      adj_q[3] <= adj_q[2];
    end
    if (en_w[5]) begin
      dneg5_q <= det_q[DetW-1];
      zero5_q <= det_q == '0;
      dabs_q  <= det_q[DetW-1] ? DetW'(-det_q) : DetW'(det_q);
      for (int k = 0; k < 9; k++) begin
        aneg_q[k] <= adj_q[3][k][AdjW-1];
        aabs_q[k] <= adj_q[3][k][AdjW-1] ? AdjW'(-adj_q[3][k]) : AdjW'(adj_q[3][k]);
      end
    end
    if (en_w[6]) begin
      for (int k = 0; k < 9; k++) begin
        num_q[k] <= (NumW'(aabs_q[k]) << (2 * FRAC_BITS + 1)) + NumW'(dabs_q);
        neg_q[k] <= aneg_q[k] ^ dneg5_q;
      end
      den_q   <= {dabs_q, 1'b0};
      zero6_q <= zero5_q;
      dneg6_q <= dneg5_q;
      dmag_q  <= dsum_w >> (2 * FRAC_BITS);
    end
  end

  // determinant and singular flag ride along beside the dividers
  logic signed [EntryW-1:0] dval_d;
  logic signed [EntryW-1:0] dval_q [DivStages];
  logic                     sing_q [DivStages];
  logic                     dsat_w;

  assign dsat_w = |dmag_q[DetW:EntryW-1];

  always_comb begin
    if (zero6_q) begin
      dval_d = '0;
    end else if (dsat_w) begin
      dval_d = dneg6_q ? ResMin : ResMax;
    end else if (dneg6_q) begin
      dval_d = -$signed(dmag_q[EntryW-1:0]);
    end else begin
      dval_d = $signed(dmag_q[EntryW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_w[DivBase]) begin
      dval_q[0] <= dval_d;
      sing_q[0] <= zero6_q;
    end
    for (int k = 1; k < DivStages; k++) begin
      if (en_w[DivBase+k]) begin
        dval_q[k] <= dval_q[k-1];
        sing_q[k] <= sing_q[k-1];
      end
    end
  end

  // nine dividers advance in lockstep with the carried flags
  logic signed [EntryW-1:0] res_w [9];

  for (genvar k = 0; k < 9; k++) begin : g_div
    minv_div #(
      .FRAC_BITS(FRAC_BITS)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en_w[DivBase +: DivStages]),
      .num_i (num_q[k]),
      .den_i (den_q),
      .neg_i (neg_q[k]),
      .clr_i (zero6_q),
      .res_o (res_w[k])
    );
  end

  assign out_data_o.b11       = res_w[0];
  assign out_data_o.b12       = res_w[1];
  assign out_data_o.b13       = res_w[2];
  assign out_data_o.b21       = res_w[3];
  assign out_data_o.b22       = res_w[4];
  assign out_data_o.b23       = res_w[5];
  assign out_data_o.b31       = res_w[6];
  assign out_data_o.b32       = res_w[7];
  assign out_data_o.b33       = res_w[8];
  assign out_data_o.det_value = dval_q[DivStages-1];
  assign out_data_o.singular  = sing_q[DivStages-1];

  // a singular result carries a zero determinant and zeros on the inverse diagonal
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.singular |->
      out_data_o.det_value == '0 && out_data_o.b11 == '0 &&
      out_data_o.b22 == '0 && out_data_o.b33 == '0)
    else $error("singular result with nonzero entries");

  // input is held back only while the first stage is occupied
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> vld_q[0])
    else $error("input stalled with empty first stage");

  // an accepted transaction lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> vld_q[0])
    else $error("accepted transaction lost");

  // a free output draws the last full stage forward
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i && vld_q[NS-2] |=> out_valid_o)
    else $error("result did not advance to output");

endmodule
